// ===== src/albl_pkg.sv =====
// ---------------------------------------------------------------------------
// albl_pkg
// Shared types and constants of the antialiased line blender.
// ---------------------------------------------------------------------------
package albl_pkg;

	localparam int CANVAS_WIDTH_DEF  = 256;
	localparam int CANVAS_HEIGHT_DEF = 128;
	localparam int FRAC_BITS_DEF     = 16;

	// coordinate width of u and v, room for v + 1 on a steep line
	localparam int CW = 9;
	// blend numerator width: 255*255 + 255*255 < 2^17
	localparam int NW = 17;
	localparam logic [7:0] CH_MAX = 8'd255;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RD_ADDR,
		ST_RD_DATA,
		ST_SETUP,
		ST_GDIV,
		ST_P_PREP,
		ST_P_RD,
		ST_P_SUM,
		ST_P_DIV,
		ST_P_WR,
		ST_DONE
	} albl_state_t;

	typedef struct packed {
		logic clr_step;
		logic load;
		logic rd_issue;
		logic rd_capture;
		logic setup;
		logic gdiv_step;
		logic p_prep;
		logic p_read;
		logic p_sum;
		logic bdiv_step;
		logic p_write;
		logic p_next;
	} albl_cmd_t;

	typedef struct packed {
		logic clr_done;
		logic gdiv_done;
		logic on_canvas;
		logic sum_zero;
		logic bdiv_done;
		logic plot_last;
	} albl_stat_t;

endpackage

// ===== src/albl_ctrl.sv =====
// ---------------------------------------------------------------------------
// albl_ctrl
// Sequencer: clear pass, request handshake and the per-pixel blend steps.
// ---------------------------------------------------------------------------
module albl_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                op,
	output logic                out_valid,
	input  logic                out_stall,
	output albl_pkg::albl_cmd_t cmd,
	input  albl_pkg::albl_stat_t stat
);

	albl_pkg::albl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= albl_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_stall  = 1'b1;
		out_valid = 1'b0;
		case (state_q)
			albl_pkg::ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (stat.clr_done) state_d = albl_pkg::ST_IDLE;
			end
			albl_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = op ? albl_pkg::ST_RD_ADDR : albl_pkg::ST_SETUP;
				end
			end
			albl_pkg::ST_RD_ADDR: begin
				cmd.rd_issue = 1'b1;
				state_d      = albl_pkg::ST_RD_DATA;
			end
			albl_pkg::ST_RD_DATA: begin
				cmd.rd_capture = 1'b1;
				state_d        = albl_pkg::ST_DONE;
			end
			albl_pkg::ST_SETUP: begin
				cmd.setup = 1'b1;
				state_d   = albl_pkg::ST_GDIV;
			end
			albl_pkg::ST_GDIV: begin
				if (stat.gdiv_done) begin
					state_d = albl_pkg::ST_P_PREP;
				end else begin
					cmd.gdiv_step = 1'b1;
				end
			end
			albl_pkg::ST_P_PREP: begin
				cmd.p_prep = 1'b1;
				state_d    = albl_pkg::ST_P_RD;
			end
			albl_pkg::ST_P_RD: begin
				if (stat.on_canvas) begin
					cmd.p_read = 1'b1;
					state_d    = albl_pkg::ST_P_SUM;
				end else begin
					cmd.p_next = 1'b1;
					state_d    = stat.plot_last ? albl_pkg::ST_DONE : albl_pkg::ST_P_PREP;
				end
			end
			albl_pkg::ST_P_SUM: begin
				if (stat.sum_zero) begin
					cmd.p_next = 1'b1;
					state_d    = stat.plot_last ? albl_pkg::ST_DONE : albl_pkg::ST_P_PREP;
				end else begin
					cmd.p_sum = 1'b1;
					state_d   = albl_pkg::ST_P_DIV;
				end
			end
			albl_pkg::ST_P_DIV: begin
				if (stat.bdiv_done) begin
					state_d = albl_pkg::ST_P_WR;
				end else begin
					cmd.bdiv_step = 1'b1;
				end
			end
			albl_pkg::ST_P_WR: begin
				cmd.p_write = 1'b1;
				cmd.p_next  = 1'b1;
				state_d     = stat.plot_last ? albl_pkg::ST_DONE : albl_pkg::ST_P_PREP;
			end
			albl_pkg::ST_DONE: begin
				out_valid = 1'b1;
				if (!out_stall) state_d = albl_pkg::ST_IDLE;
			end
			default: begin
				state_d = albl_pkg::ST_CLEAR;
			end
		endcase
	end

	// one request in flight: no new request while a result waits
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("request taken while a result is pending");

endmodule

// ===== src/albl_dp.sv =====
// ---------------------------------------------------------------------------
// albl_dp
// Datapath: frame memory, gradient divider, plot walker and blend divider.
// ---------------------------------------------------------------------------
module albl_dp #(
	parameter int CANVAS_WIDTH  = albl_pkg::CANVAS_WIDTH_DEF,
	parameter int CANVAS_HEIGHT = albl_pkg::CANVAS_HEIGHT_DEF,
	parameter int FRAC_BITS     = albl_pkg::FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  albl_pkg::albl_cmd_t  cmd,
	output albl_pkg::albl_stat_t stat,
	input  logic                 op,
	input  logic [7:0]           x_start,
	input  logic [6:0]           y_start,
	input  logic [7:0]           x_end,
	input  logic [6:0]           y_end,
	input  logic [7:0]           colour_red,
	input  logic [7:0]           colour_green,
	input  logic [7:0]           colour_blue,
	input  logic [7:0]           colour_alpha,
	output logic                 is_read,
	output logic [7:0]           pixel_red,
	output logic [7:0]           pixel_green,
	output logic [7:0]           pixel_blue,
	output logic [7:0]           pixel_alpha
);

	localparam int CW    = albl_pkg::CW;
	localparam int NW    = albl_pkg::NW;
	localparam int DEPTH = CANVAS_WIDTH * CANVAS_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int DW    = 8 + FRAC_BITS;          // gradient dividend width
	localparam int GCW   = $clog2(DW + 1);
	localparam int BCW   = $clog2(NW + 1);
	localparam int TW    = FRAC_BITS + CW + 2;     // signed intercept width

	// request registers
	logic [7:0] xs_q, xe_q, br_q, bg_q, bb_q, ba_q;
	logic [6:0] ys_q, ye_q;
	logic       is_read_q;
	logic [7:0] pix_q [4];

	// line geometry
	logic          steep_q, neg_q;
	logic [CW-1:0] u0_q, v0_q, u1_q, v1_q, du_q;

	// gradient divider
	logic [DW-1:0]  gquo_q;
	logic [CW:0]    grem_q;
	logic [GCW-1:0] gcnt_q;

	// plot walker
	logic          interior_q, half_q;
	logic [1:0]    ep_q;
	logic [CW-1:0] col_q;
	logic signed [TW-1:0] t_q;

	// current pixel
	logic [CW-1:0] px_q, py_q;
	logic          on_q;
	logic [7:0]    a_q, s_q;

	// blend divider
	logic [NW-1:0]  num_q [3];
	logic [8:0]     rem_q [3];
	logic [BCW-1:0] bcnt_q;

	// frame memory
	logic [31:0]   mem [DEPTH];
	logic [31:0]   rdata_q;
	logic [AW-1:0] clr_q;
	logic [AW-1:0] addr_w;

	assign addr_w = AW'(32'(py_q) * CANVAS_WIDTH + 32'(px_q));

	// ---- setup: axis swap and endpoint order
	logic [7:0]    adx_w, ady_w;
	logic          steep_w, swap_w;
	logic [CW-1:0] a0_w, b0_w, a1_w, b1_w, su0_w, sv0_w, su1_w, sv1_w;
	logic          sneg_w;
	logic [CW-1:0] sdv_w;

	always_comb begin
		adx_w   = (xe_q >= xs_q) ? (xe_q - xs_q) : (xs_q - xe_q);
		ady_w   = 8'((ye_q >= ys_q) ? (ye_q - ys_q) : (ys_q - ye_q));
		steep_w = ady_w > adx_w;
		a0_w    = steep_w ? CW'(ys_q) : CW'(xs_q);
		b0_w    = steep_w ? CW'(xs_q) : CW'(ys_q);
		a1_w    = steep_w ? CW'(ye_q) : CW'(xe_q);
		b1_w    = steep_w ? CW'(xe_q) : CW'(ye_q);
		swap_w  = a0_w > a1_w;
		su0_w   = swap_w ? a1_w : a0_w;
		sv0_w   = swap_w ? b1_w : b0_w;
		su1_w   = swap_w ? a0_w : a1_w;
		sv1_w   = swap_w ? b0_w : b1_w;
		sneg_w  = sv1_w < sv0_w;
		sdv_w   = sneg_w ? (sv0_w - sv1_w) : (sv1_w - sv0_w);
	end

	// ---- gradient from the divider result
	logic [CW:0]           grem2_w;
	logic                  gge_w;
	logic signed [TW-1:0]  g_w;
	logic [TW-1:0]         gmag_w;

	assign grem2_w = {grem_q[CW-1:0], gquo_q[DW-1]};
	assign gge_w   = grem2_w >= {1'b0, du_q};
	assign gmag_w  = (du_q == '0) ? '0 : TW'(gquo_q[FRAC_BITS:0]);
	assign g_w     = neg_q ? -signed'(gmag_w) : signed'(gmag_w);

	// ---- plot walker: coordinates and coverage alpha of the next pixel
	logic [CW-1:0]          ip_w, u_w, v_w;
	logic [FRAC_BITS-1:0]   f_w;
	logic [FRAC_BITS:0]     cov_w;
	logic [FRAC_BITS+8:0]   prod_w;
	logic [7:0]             alpha_w;
	logic signed [TW-1:0]   t0_w;

	assign t0_w = signed'({2'b00, v0_q, {FRAC_BITS{1'b0}}}) + g_w;

	always_comb begin
		ip_w   = t_q[TW-1] ? '0 : t_q[FRAC_BITS +: CW];
		f_w    = t_q[TW-1] ? '0 : t_q[FRAC_BITS-1:0];
		cov_w  = half_q ? {1'b0, f_w} : ({1'b1, {FRAC_BITS{1'b0}}} - {1'b0, f_w});
		prod_w = cov_w * ba_q;
		if (interior_q) begin
			u_w     = col_q;
			v_w     = half_q ? (ip_w + 1'b1) : ip_w;
			alpha_w = prod_w[FRAC_BITS +: 8];
		end else begin
			u_w     = ep_q[1] ? u1_q : u0_q;
			v_w     = (ep_q[1] ? v1_q : v0_q) + CW'(ep_q[0]);
			alpha_w = ep_q[0] ? 8'd0 : (ba_q >> 1);
		end
	end

	// ---- blend terms
	logic [8:0] sum_w;
	logic [7:0] sat_w;
	logic [7:0] cur_w [3];
	logic [7:0] brush_w [3];
	logic [7:0] res_w [3];

	assign sum_w      = {1'b0, rdata_q[31:24]} + {1'b0, a_q};
	assign sat_w      = sum_w[8] ? albl_pkg::CH_MAX : sum_w[7:0];
	assign cur_w[0]   = rdata_q[7:0];
	assign cur_w[1]   = rdata_q[15:8];
	assign cur_w[2]   = rdata_q[23:16];
	assign brush_w[0] = br_q;
	assign brush_w[1] = bg_q;
	assign brush_w[2] = bb_q;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			res_w[c] = (num_q[c] > NW'(albl_pkg::CH_MAX)) ? albl_pkg::CH_MAX : num_q[c][7:0];
		end
	end

	always_comb begin
		stat.clr_done  = clr_q == AW'(DEPTH - 1);
		stat.gdiv_done = gcnt_q == '0;
		stat.on_canvas = on_q;
		stat.sum_zero  = sum_w == '0;
		stat.bdiv_done = bcnt_q == '0;
		stat.plot_last = interior_q
			? (half_q && ({1'b0, col_q} + 1'b1 >= {1'b0, u1_q}))
			: ((ep_q == 2'd3) && ({1'b0, u0_q} + 1'b1 >= {1'b0, u1_q}));
	end

	// ---- control-state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= '0;
			gcnt_q <= '0;
			bcnt_q <= '0;
		end else begin
			if (cmd.clr_step) clr_q <= clr_q + 1'b1;
			if (cmd.setup) begin
				gcnt_q <= GCW'(DW);
			end else if (cmd.gdiv_step) begin
				gcnt_q <= gcnt_q - 1'b1;
			end
			if (cmd.p_sum) begin
				bcnt_q <= BCW'(NW);
			end else if (cmd.bdiv_step) begin
				bcnt_q <= bcnt_q - 1'b1;
			end
		end
	end

	// ---- payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			xs_q      <= x_start;
			ys_q      <= y_start;
			xe_q      <= x_end;
			ye_q      <= y_end;
			br_q      <= colour_red;
			bg_q      <= colour_green;
			bb_q      <= colour_blue;
			ba_q      <= colour_alpha;
			is_read_q <= op;
			px_q      <= CW'(x_start);
			py_q      <= CW'(y_start);
			on_q      <= (32'(x_start) < CANVAS_WIDTH) && (32'(y_start) < CANVAS_HEIGHT);
			for (int c = 0; c < 4; c++) pix_q[c] <= '0;
		end
		if (cmd.rd_capture && on_q) begin
			pix_q[0] <= rdata_q[7:0];
			pix_q[1] <= rdata_q[15:8];
			pix_q[2] <= rdata_q[23:16];
			pix_q[3] <= rdata_q[31:24];
		end

		if (cmd.setup) begin
			steep_q    <= steep_w;
			neg_q      <= sneg_w;
			u0_q       <= su0_w;
			v0_q       <= sv0_w;
			u1_q       <= su1_w;
			v1_q       <= sv1_w;
			du_q       <= su1_w - su0_w;
			gquo_q     <= {sdv_w[7:0], {FRAC_BITS{1'b0}}};
			grem_q     <= '0;
			ep_q       <= '0;
			interior_q <= 1'b0;
			half_q     <= 1'b0;
		end else if (cmd.gdiv_step) begin
			grem_q <= gge_w ? (grem2_w - {1'b0, du_q}) : grem2_w;
			gquo_q <= {gquo_q[DW-2:0], gge_w};
		end

		if (cmd.p_prep) begin
			px_q <= steep_q ? v_w : u_w;
			py_q <= steep_q ? u_w : v_w;
			on_q <= (32'(steep_q ? v_w : u_w) < CANVAS_WIDTH)
				&& (32'(steep_q ? u_w : v_w) < CANVAS_HEIGHT);
			a_q  <= alpha_w;
		end

		if (cmd.p_next) begin
			if (!interior_q) begin
				if (ep_q == 2'd3) begin
					interior_q <= 1'b1;
					col_q      <= u0_q + 1'b1;
					half_q     <= 1'b0;
					t_q        <= t0_w;
				end else begin
					ep_q <= ep_q + 1'b1;
				end
			end else if (!half_q) begin
				half_q <= 1'b1;
			end else begin
				half_q <= 1'b0;
				col_q  <= col_q + 1'b1;
				t_q    <= t_q + g_w;
			end
		end

		if (cmd.p_sum) begin
			s_q <= sat_w;
			for (int c = 0; c < 3; c++) begin
				num_q[c] <= NW'(cur_w[c] * (albl_pkg::CH_MAX - a_q)) + NW'(brush_w[c] * a_q);
				rem_q[c] <= '0;
			end
		end else if (cmd.bdiv_step) begin
			for (int c = 0; c < 3; c++) begin
				if ({rem_q[c][7:0], num_q[c][NW-1]} >= {1'b0, s_q}) begin
					rem_q[c] <= {rem_q[c][7:0], num_q[c][NW-1]} - {1'b0, s_q};
					num_q[c] <= {num_q[c][NW-2:0], 1'b1};
				end else begin
					rem_q[c] <= {rem_q[c][7:0], num_q[c][NW-1]};
					num_q[c] <= {num_q[c][NW-2:0], 1'b0};
				end
			end
		end
	end

	// ---- frame memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.clr_step) begin
			mem[clr_q] <= '0;
		end else if (cmd.p_write) begin
			mem[addr_w] <= {s_q, res_w[2], res_w[1], res_w[0]};
		end
		if (cmd.rd_issue || cmd.p_read) begin
			rdata_q <= mem[addr_w];
		end
	end

	assign is_read     = is_read_q;
	assign pixel_red   = pix_q[0];
	assign pixel_green = pix_q[1];
	assign pixel_blue  = pix_q[2];
	assign pixel_alpha = pix_q[3];

	a_wr_on_canvas: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.p_write |-> on_q)
		else $error("blend write outside the canvas");

	a_wr_nonzero_sum: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.p_write |-> (s_q != '0))
		else $error("blend write with zero alpha sum");

	// a zero major span leaves the quotient unused
	a_grad_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.p_prep |-> ((du_q == '0) || (gquo_q <= DW'(1) << FRAC_BITS)))
		else $error("gradient magnitude above one");

endmodule

// ===== src/antialiased_line_blend_top.sv =====
// ---------------------------------------------------------------------------
// antialiased_line_blend_top
// Wu antialiased line drawing with alpha blending into an RGBA frame memory.
// ---------------------------------------------------------------------------
//
//  channel | handshake          | payload
//  --------+--------------------+------------------------------------------
//  in      | in_valid/in_stall  | op, x_start, y_start, x_end, y_end, colour_*
//  out     | out_valid/out_stall| is_read, pixel_red/green/blue/alpha
//
// After reset the frame memory is swept to zero, one pixel per cycle, with
// in_stall held high. A read request passes ST_RD_ADDR (registered memory
// read) and ST_RD_DATA (pixel capture) before its result is valid. A line
// request runs setup and the bit-serial gradient division; then a pixel off
// the canvas is skipped, one on it is read and, unless its alpha sum is
// zero, blended through the bit-serial channel divider and written back;
// 2*du+2 pixels per line, 4 when both endpoints share the major coordinate.
// One request is in flight at a time; a pending result holds until out_stall
// drops, and the next request is taken after that.
// ---------------------------------------------------------------------------
module antialiased_line_blend_top #(
	parameter int CANVAS_WIDTH  = albl_pkg::CANVAS_WIDTH_DEF,
	parameter int CANVAS_HEIGHT = albl_pkg::CANVAS_HEIGHT_DEF,
	parameter int FRAC_BITS     = albl_pkg::FRAC_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       op,
	input  logic [7:0] x_start,
	input  logic [6:0] y_start,
	input  logic [7:0] x_end,
	input  logic [6:0] y_end,
	input  logic [7:0] colour_red,
	input  logic [7:0] colour_green,
	input  logic [7:0] colour_blue,
	input  logic [7:0] colour_alpha,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       is_read,
	output logic [7:0] pixel_red,
	output logic [7:0] pixel_green,
	output logic [7:0] pixel_blue,
	output logic [7:0] pixel_alpha
);

	albl_pkg::albl_cmd_t  cmd;
	albl_pkg::albl_stat_t stat;

	// sequencer: owns the handshakes and steps the datapath
	albl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.op        (op),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.stat      (stat)
	);

	// datapath: frame memory, dividers, plot walker, result registers
	albl_dp #(
		.CANVAS_WIDTH  (CANVAS_WIDTH),
		.CANVAS_HEIGHT (CANVAS_HEIGHT),
		.FRAC_BITS     (FRAC_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.op           (op),
		.x_start      (x_start),
		.y_start      (y_start),
		.x_end        (x_end),
		.y_end        (y_end),
		.colour_red   (colour_red),
		.colour_green (colour_green),
		.colour_blue  (colour_blue),
		.colour_alpha (colour_alpha),
		.is_read      (is_read),
		.pixel_red    (pixel_red),
		.pixel_green  (pixel_green),
		.pixel_blue   (pixel_blue),
		.pixel_alpha  (pixel_alpha)
	);

endmodule
